@@ design/ille_pkg.sv @@
`timescale 1ns / 1ps
// Package for the indexed linked list engine: sizes, operation and status codes,
// and the token that travels down the cell chain. No dependencies.
package ille_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Operation codes on op_i
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  // Status codes on status_o
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // What a cell does once the token reaches the target element
  typedef enum logic [1:0] {
    KIND_INS,
    KIND_REM,
    KIND_RD
  } ille_kind_e;

  // Token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic                   vld;
    ille_kind_e             kind;
    logic                   hit;   // removed value already captured
    logic [IDX_W-1:0]       skip;  // cells left to pass before the target
    logic [CNT_W-1:0]       span;  // cells left to act on
    logic [VALUE_WIDTH-1:0] data;  // carried value
  } ille_tok_t;

endpackage

@@ design/ille_cell.sv @@
`timescale 1ns / 1ps
// One cell of the list chain: holds one element in list order and passes the
// token to its right neighbor every cycle. Depends on ille_pkg.
module ille_cell import ille_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ille_tok_t              tok_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  output ille_tok_t              tok_o,
  output logic [VALUE_WIDTH-1:0] val_o
);

  ille_tok_t              tok_q, tok_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;

  // Count down to the target, then act on span cells
  always_comb begin
    tok_d = tok_i;
    val_d = val_q;
    if (tok_i.vld) begin
      if (tok_i.skip != '0) begin
        tok_d.skip = tok_i.skip - 1'b1;
      end else if (tok_i.span != '0) begin
        tok_d.span = tok_i.span - 1'b1;
        case (tok_i.kind)
          KIND_INS: begin
            // ripple the old element one place right
            val_d      = tok_i.data;
            tok_d.data = val_q;
          end
          KIND_REM: begin
            // close the gap from the right neighbor
            val_d = right_i;
            if (!tok_i.hit) begin
              tok_d.data = val_q;
              tok_d.hit  = 1'b1;
            end
          end
          KIND_RD: begin
            tok_d.data = val_q;
          end
          default: begin
            tok_d = tok_i;
          end
        endcase
      end
    end
  end

  // Hand the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Element storage
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign tok_o = tok_q;
  assign val_o = val_q;

endmodule

@@ design/indexed_linked_list_engine_core.sv @@
`timescale 1ns / 1ps
// Indexed linked list engine: list kept in order in a chain of CAPACITY cells.
// Push, pop, insert, remove and read send a token through every cell: the result
// strobe comes once the token leaves the last cell, and busy holds off the next start.
// Refused requests and clear answer in the next cycle and allow a start every cycle.
// The cell chain length sets the walk time; the receiver cannot stall results.
// Reset empties the list and clears the strobe and busy.
module indexed_linked_list_engine_core import ille_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [6:0]  element_count_o,
  output logic [1:0]  status_o
);

  ille_tok_t              tok [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] val [CAPACITY+1];

  logic [CNT_W-1:0] count_q, count_d;
  logic             busy_q;
  ille_tok_t        launch_q, launch_d;
  logic             done_q;
  logic [31:0]      rd_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic [1:0]       status_q, st_d;

  logic             accept;
  logic             walk;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] idx;
  ille_kind_e       kind;

  assign accept  = start && !busy_q;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign pos_ext = CNT_W'(position_i);

  // Decode the operation and check it against the current count
  always_comb begin
    walk    = 1'b0;
    st_d    = ST_OK;
    count_d = count_q;
    kind    = KIND_RD;
    idx     = '0;
    case (op_i)
      OP_PUSH_BACK: begin
        if (full) st_d = ST_FULL;
        else begin
          walk = 1'b1; kind = KIND_INS; idx = count_q;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) st_d = ST_FULL;
        else begin
          walk = 1'b1; kind = KIND_INS;
        end
      end
      OP_POP_FRONT: begin
        if (empty) st_d = ST_EMPTY;
        else begin
          walk = 1'b1; kind = KIND_REM;
        end
      end
      OP_POP_BACK: begin
        if (empty) st_d = ST_EMPTY;
        else begin
          walk = 1'b1; kind = KIND_REM; idx = count_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) st_d = ST_FULL;
        else if (pos_ext > count_q) st_d = ST_RANGE;
        else begin
          walk = 1'b1; kind = KIND_INS; idx = pos_ext;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (empty) st_d = ST_EMPTY;
        else if (pos_ext >= count_q) st_d = ST_RANGE;
        else begin
          walk = 1'b1; idx = pos_ext;
          kind = (op_i == OP_REMOVE) ? KIND_REM : KIND_RD;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    if (walk && kind == KIND_INS) count_d = count_q + 1'b1;
    if (walk && kind == KIND_REM) count_d = count_q - 1'b1;

    launch_d      = '0;
    launch_d.vld  = accept && walk;
    launch_d.kind = kind;
    launch_d.skip = idx[IDX_W-1:0];
    launch_d.data = VALUE_WIDTH'(value_i);
    case (kind)
      KIND_INS: launch_d.span = count_q - idx + 1'b1;
      KIND_REM: launch_d.span = count_q - idx;
      KIND_RD:  launch_d.span = CNT_W'(1);
      default:  launch_d.span = '0;
    endcase
  end

  // Control: count, busy flag, launch and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      launch_q <= '0;
      done_q   <= 1'b0;
    end else begin
      launch_q <= launch_d;
      done_q   <= 1'b0;
      if (accept) begin
        count_q <= count_d;
        if (walk) busy_q <= 1'b1;
        else done_q <= 1'b1;
      end else if (tok[CAPACITY].vld) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= '0;
      res_cnt_q <= count_d;
      status_q  <= st_d;
    end else if (tok[CAPACITY].vld) begin
      rd_q      <= (tok[CAPACITY].kind == KIND_INS) ? '0 : 32'(tok[CAPACITY].data);
      res_cnt_q <= count_q;
      status_q  <= ST_OK;
    end
  end

  // Chain of cells, element i held in cell i
  assign tok[0]        = launch_q;
  assign val[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ille_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[i]),
      .right_i (val[i+1]),
      .tok_o   (tok[i+1]),
      .val_o   (val[i])
    );
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign read_value_o    = rd_q;
  assign element_count_o = 7'(res_cnt_q);
  assign status_o        = status_q;

endmodule

@@ design/ille_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the indexed linked list engine, bound to the top level.
// Depends on ille_pkg.
module ille_checker import ille_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [6:0]  element_count_o,
  input logic [1:0]  status_o
);

  // Every transaction gives a result or starts a walk
  a_start_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("transaction taken without result or walk");

  // A walk ends with its result
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without result");

  // A walk starts with no result pending
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("result shown as a walk starts");

  // Full status only with a full list
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (element_count_o == 7'(CAPACITY)))
    else $error("full status with room left");

  // Empty status only with an empty list
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (element_count_o == '0))
    else $error("empty status with elements held");

endmodule

bind indexed_linked_list_engine_core ille_checker u_ille_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .element_count_o (element_count_o),
  .status_o        (status_o)
);
